// File: rtl/core/rcrq_pkg.sv
// Shared types, codes and widths of the read completion reorder queue.
package rcrq_pkg;

   localparam int RING_SLOTS_DEF = 16;

   localparam int OP_W     = 2;
   localparam int ADDR_W   = 32;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 4;

   // item operations
   localparam logic [OP_W-1:0] OP_ENQUEUE  = 2'd0;
   localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
   localparam logic [OP_W-1:0] OP_RETIRE   = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STS_UNMATCHED = 2'd2;
   localparam logic [STATUS_W-1:0] STS_NOT_READY = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RETIRE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic               ready;
      logic [ADDR_W-1:0]  addr;
      logic [VALUE_W-1:0] value;
   } slot_type;

endpackage

// File: rtl/core/rcrq_if.sv
// Valid/ready channel interfaces for the request and response beats.
interface rcrq_req_if;
   import rcrq_pkg::*;
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [ADDR_W-1:0]  addr;
   logic [VALUE_W-1:0] rd_value;
   modport source (output valid, op, addr, rd_value, input ready);
   modport sink   (input valid, op, addr, rd_value, output ready);
endinterface

interface rcrq_rsp_if;
   import rcrq_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   head_addr;
   logic [VALUE_W-1:0]  head_value;
   logic [OCC_W-1:0]    occupancy;
   modport source (output valid, status, head_addr, head_value, occupancy, input ready);
   modport sink   (input valid, status, head_addr, head_value, occupancy, output ready);
endinterface

// File: rtl/core/read_completion_reorder_queue.sv
// Read completion reorder queue: ring of outstanding reads kept in one slot memory.
//
// Usage:
//  - req_bus carries one beat per item: op (enqueue, completion, retire head),
//    addr and rd_value. rsp_bus returns exactly one beat per item: status,
//    head_addr, head_value and the occupancy after the item.
//  - Items are handled one at a time. An enqueue or an unused op goes straight
//    to ST_RESULT; a retire on a non-empty ring first reads the head slot.
//  - A completion walks the ring from the head, one slot memory read per cycle,
//    and the number of slots examined is 1 to RING_SLOTS-1. The single read port
//    of the slot memory sets this rate.
//  - At most RING_SLOTS-1 entries are held; an enqueue into a full ring is
//    dropped and flagged.
//  - Reset clears the head and tail pointers and the response valid flag. The
//    slot memory is not cleared: only slots between head and tail are read.
//  - The response register decouples the sides: a new request is accepted while
//    a finished response waits. If the receiver stalls, the next item finishes
//    its work and holds its result until the response register frees up.
module read_completion_reorder_queue #(
   parameter int RING_SLOTS = rcrq_pkg::RING_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rcrq_req_if.sink    req_bus,
   rcrq_rsp_if.source  rsp_bus
);
   import rcrq_pkg::*;

   localparam int PTR_W = $clog2(RING_SLOTS);
   localparam int CNT_W = PTR_W + 1;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      ring_next = (p == PTR_W'(RING_SLOTS - 1)) ? '0 : p + 1'b1;
   endfunction

   // slot memory and its registered read port
   slot_type slot_mem_ff [RING_SLOTS];
   slot_type rd_data_ff;

   logic             mem_we;
   logic [PTR_W-1:0] mem_wa;
   slot_type         mem_wd;
   logic [PTR_W-1:0] mem_ra;

   // control registers
   state_type        state_ff,  state_in;
   logic [PTR_W-1:0] head_ff,   head_in;
   logic [PTR_W-1:0] tail_ff,   tail_in;
   logic [PTR_W-1:0] scan_ff,   scan_in;
   logic             out_valid_ff, out_valid_in;

   // item and result payload
   logic [ADDR_W-1:0]   item_addr_ff,   item_addr_in;
   logic [VALUE_W-1:0]  item_value_ff,  item_value_in;
   logic [STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic [ADDR_W-1:0]   pend_addr_ff,   pend_addr_in;
   logic [VALUE_W-1:0]  pend_value_ff,  pend_value_in;
   logic [STATUS_W-1:0] out_status_ff,  out_status_in;
   logic [ADDR_W-1:0]   out_addr_ff,    out_addr_in;
   logic [VALUE_W-1:0]  out_value_ff,   out_value_in;
   logic [OCC_W-1:0]    out_occ_ff,     out_occ_in;

   logic             accept;
   logic             out_free;
   logic             ring_empty;
   logic             ring_full;
   logic             scan_hit;
   logic             scan_last;
   logic [CNT_W-1:0] ring_count;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign ring_empty    = (head_ff == tail_ff);
   assign ring_full     = (ring_next(tail_ff) == head_ff);
   // skip slots that already hold data so duplicate addresses fill in order
   assign scan_hit      = (rd_data_ff.addr == item_addr_ff) && !rd_data_ff.ready;
   assign scan_last     = (ring_next(scan_ff) == tail_ff);
   assign ring_count    = (tail_ff >= head_ff)
                        ? ({1'b0, tail_ff} - {1'b0, head_ff})
                        : ({1'b0, tail_ff} + CNT_W'(RING_SLOTS) - {1'b0, head_ff});

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.status     = out_status_ff;
   assign rsp_bus.head_addr  = out_addr_ff;
   assign rsp_bus.head_value = out_value_ff;
   assign rsp_bus.occupancy  = out_occ_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_bus.op == OP_COMPLETE && !ring_empty) begin
                  state_in = ST_SCAN;
               end else if (req_bus.op == OP_RETIRE && !ring_empty) begin
                  state_in = ST_RETIRE;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_SCAN: begin
            if (scan_hit || scan_last) begin
               state_in = ST_RESULT;
            end
         end
         ST_RETIRE: state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      scan_in        = scan_ff;
      mem_we         = 1'b0;
      mem_wa         = tail_ff;
      mem_wd         = '{ready: 1'b0, addr: req_bus.addr, value: '0};
      mem_ra         = scan_ff;
      item_addr_in   = item_addr_ff;
      item_value_in  = item_value_ff;
      pend_status_in = pend_status_ff;
      pend_addr_in   = pend_addr_ff;
      pend_value_in  = pend_value_ff;
      out_valid_in   = out_valid_ff && !rsp_bus.ready;
      out_status_in  = out_status_ff;
      out_addr_in    = out_addr_ff;
      out_value_in   = out_value_ff;
      out_occ_in     = out_occ_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_addr_in   = req_bus.addr;
               item_value_in  = req_bus.rd_value;
               pend_status_in = STS_OK;
               pend_addr_in   = '0;
               pend_value_in  = '0;
               case (req_bus.op)
                  OP_ENQUEUE: begin
                     if (ring_full) begin
                        pend_status_in = STS_FULL;
                     end else begin
                        mem_we  = 1'b1;
                        tail_in = ring_next(tail_ff);
                     end
                  end
                  OP_COMPLETE: begin
                     if (ring_empty) begin
                        pend_status_in = STS_UNMATCHED;
                     end else begin
                        mem_ra  = head_ff;
                        scan_in = head_ff;
                     end
                  end
                  OP_RETIRE: begin
                     if (ring_empty) begin
                        pend_status_in = STS_NOT_READY;
                     end else begin
                        mem_ra = head_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               // write back the matched slot with its data
               mem_we = 1'b1;
               mem_wa = scan_ff;
               mem_wd = '{ready: 1'b1, addr: rd_data_ff.addr, value: item_value_ff};
            end else if (scan_last) begin
               pend_status_in = STS_UNMATCHED;
            end else begin
               scan_in = ring_next(scan_ff);
               mem_ra  = ring_next(scan_ff);
            end
         end
         ST_RETIRE: begin
            if (rd_data_ff.ready) begin
               pend_addr_in  = rd_data_ff.addr;
               pend_value_in = rd_data_ff.value;
               head_in       = ring_next(head_ff);
            end else begin
               pend_status_in = STS_NOT_READY;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = pend_status_ff;
               out_addr_in   = pend_addr_ff;
               out_value_in  = pend_value_ff;
               out_occ_in    = OCC_W'(ring_count);
            end
         end
         default: ;
      endcase
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= slot_mem_ff[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         scan_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         scan_ff      <= scan_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_addr_ff   <= item_addr_in;
      item_value_ff  <= item_value_in;
      pend_status_ff <= pend_status_in;
      pend_addr_ff   <= pend_addr_in;
      pend_value_ff  <= pend_value_in;
      out_status_ff  <= out_status_in;
      out_addr_ff    <= out_addr_in;
      out_value_ff   <= out_value_in;
      out_occ_ff     <= out_occ_in;
   end

endmodule

// File: rtl/core/rcrq_checker.sv
// Port-level checks for the read completion reorder queue, bound to the top level.
module rcrq_checker #(
   parameter int RING_SLOTS = rcrq_pkg::RING_SLOTS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rcrq_pkg::STATUS_W-1:0] rsp_status,
   input logic [rcrq_pkg::ADDR_W-1:0]   rsp_head_addr,
   input logic [rcrq_pkg::VALUE_W-1:0]  rsp_head_value,
   input logic [rcrq_pkg::OCC_W-1:0]    rsp_occupancy
);
   import rcrq_pkg::*;

   // hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable({rsp_status, rsp_head_addr, rsp_head_value, rsp_occupancy}))
      else $error("stalled response payload changed");

   // one item in flight: no request accepted right after another
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an item is in flight");

   // a dropped enqueue only happens with the ring full
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_FULL |-> rsp_occupancy == OCC_W'(RING_SLOTS - 1))
      else $error("full status with ring not full");

   // failed items return no head entry
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_FULL || rsp_status == STS_UNMATCHED ||
                    rsp_status == STS_NOT_READY)
         |-> rsp_head_addr == '0 && rsp_head_value == '0)
      else $error("failed item returned head data");

endmodule

bind read_completion_reorder_queue rcrq_checker #(.RING_SLOTS(RING_SLOTS)) u_rcrq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_head_addr  (rsp_bus.head_addr),
   .rsp_head_value (rsp_bus.head_value),
   .rsp_occupancy  (rsp_bus.occupancy)
);
